// ===== hw/rtl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 6;
  localparam int TDATA_OUT_W = 8;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_BIT,
    CELL_DIGIT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/b2da_cell.sv =====
// One BCD digit cell of the double dabble chain.
module b2da_cell (
  input  logic              clk,
  input  b2da_pkg::cell_op_t op,
  input  logic              bit_in,
  input  b2da_pkg::digit_t  digit_in,
  output b2da_pkg::digit_t  digit,
  output logic              carry
);

  b2da_pkg::digit_t corr;

  // Add three before the shift when the digit would overflow past nine.
  always_comb begin
    if (digit >= b2da_pkg::DIGIT_W'(5)) begin
      corr = digit + b2da_pkg::DIGIT_W'(3);
    end else begin
      corr = digit;
    end
  end

  assign carry = corr[b2da_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    unique case (op)
      b2da_pkg::CELL_HOLD:  digit <= digit;
      b2da_pkg::CELL_CLEAR: digit <= '0;
      b2da_pkg::CELL_BIT:   digit <= {corr[b2da_pkg::DIGIT_W-2:0], bit_in};
      b2da_pkg::CELL_DIGIT: digit <= digit_in;
      default:              digit <= digit;
    endcase
  end

endmodule

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// Top level: unsigned binary to decimal ASCII digit stream converter.
//
//   channel | dir | tdata fields (low bit up)        | tuser | tlast
//   s_*     | in  | number[INPUT_WIDTH-1:0]          | -     | -
//   m_*     | out | digit_char[5:0], zero pad [7:6]  | -     | last_digit
//
// Per number: a load, then the number shifted through the digit cell chain
// (one bit shifted per cycle), leading zeros skipped (one digit a cycle), a
// step to leave the skip phase, then the digits emitted while the output is
// not stalled. Skipped zeros and digits always sum to the cell count.
// Reset (rst, synchronous) returns the sequencer to idle, holds s_tready low
// and empties the output register; digit cells hold no reset.
// A stalled output holds the digit chain; a new request is taken only
// while idle, even with the last digit still waiting in the output register.
module binary_to_decimal_ascii #(
  parameter int INPUT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((INPUT_WIDTH+7)/8)*8-1:0] s_tdata,  // number
  output logic m_tvalid,
  input  logic m_tready,
  output logic [b2da_pkg::TDATA_OUT_W-1:0] m_tdata, // digit_char, zero pad
  output logic m_tlast                               // last_digit
);

  // Digits of 2^W-1: floor(W * log10(2)) + 1, log10(2) ~ 1233/4096.
  localparam int NDIG  = ((INPUT_WIDTH * 1233) >> 12) + 1;
  localparam int BCW   = $clog2(INPUT_WIDTH + 1);
  localparam int RCW   = $clog2(NDIG + 1);

  b2da_pkg::state_t   state, state_next;
  b2da_pkg::cell_op_t cell_op;

  logic [INPUT_WIDTH-1:0] shreg;
  logic [BCW-1:0]         bitcnt;
  logic [RCW-1:0]         remain;

  b2da_pkg::digit_t digits [NDIG];
  logic             carries [NDIG];
  b2da_pkg::digit_t top;

  logic accept;
  logic out_free;
  logic emit_now;

  assign top      = digits[NDIG-1];
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Digit chain: each cell takes its lower neighbor's carry bit (bit mode)
  // or whole digit (digit mode); the bottom cell takes the number's MSB.
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic             bin;
    b2da_pkg::digit_t din;
    if (i == 0) begin : g_first
      assign bin = shreg[INPUT_WIDTH-1];
      assign din = '0;
    end else begin : g_rest
      assign bin = carries[i-1];
      assign din = digits[i-1];
    end
    b2da_cell u_cell (
      .clk      (clk),
      .op       (cell_op),
      .bit_in   (bin),
      .digit_in (din),
      .digit    (digits[i]),
      .carry    (carries[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      b2da_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = b2da_pkg::ST_CONV;
      end
      b2da_pkg::ST_CONV: begin
        if (bitcnt == BCW'(1)) state_next = b2da_pkg::ST_SKIP;
      end
      b2da_pkg::ST_SKIP: begin
        if (top != '0 || remain == RCW'(1)) state_next = b2da_pkg::ST_EMIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (out_free && remain == RCW'(1)) state_next = b2da_pkg::ST_IDLE;
      end
      default: state_next = b2da_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    cell_op  = b2da_pkg::CELL_HOLD;
    emit_now = 1'b0;
    unique case (state)
      b2da_pkg::ST_IDLE: begin
        // Hold off requests while reset is asserted.
        s_tready = !rst;
        if (s_tvalid) cell_op = b2da_pkg::CELL_CLEAR;
      end
      b2da_pkg::ST_CONV: begin
        cell_op = b2da_pkg::CELL_BIT;
      end
      b2da_pkg::ST_SKIP: begin
        // Drop a leading zero by moving every digit up one cell.
        if (top == '0 && remain != RCW'(1)) cell_op = b2da_pkg::CELL_DIGIT;
      end
      b2da_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_now = 1'b1;
          cell_op  = b2da_pkg::CELL_DIGIT;
        end
      end
      default: begin
        cell_op = b2da_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Input shift register, bit counter and remaining digit count
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg  <= s_tdata[INPUT_WIDTH-1:0];
      bitcnt <= BCW'(INPUT_WIDTH);
      remain <= RCW'(NDIG);
    end else begin
      if (state == b2da_pkg::ST_CONV) begin
        shreg  <= {shreg[INPUT_WIDTH-2:0], 1'b0};
        bitcnt <= bitcnt - BCW'(1);
      end
      if (cell_op == b2da_pkg::CELL_DIGIT) begin
        remain <= remain - RCW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      m_tdata <= {2'b00, b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top)};
      m_tlast <= (remain == RCW'(1));
    end
  end

`ifndef SYNTHESIS
  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    state == b2da_pkg::ST_EMIT |-> remain != '0)
    else $error("emit with no digits left");

  a_top_is_bcd: assert property (@(posedge clk) disable iff (rst)
    (state == b2da_pkg::ST_SKIP || state == b2da_pkg::ST_EMIT) |-> top <= 4'd9)
    else $error("top cell holds a non-decimal digit");

  a_conv_to_skip: assert property (@(posedge clk) disable iff (rst)
    (state == b2da_pkg::ST_CONV && bitcnt == BCW'(1)) |=> state == b2da_pkg::ST_SKIP)
    else $error("conversion did not end after the last bit");

  a_out_ascii: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] == 4'b0011 && m_tdata[3:0] <= 4'd9))
    else $error("output is not an ASCII digit");
`endif

endmodule

// ===== tb/binary_to_decimal_ascii_test.sv =====
// Testbench for the binary to decimal ASCII converter: directed and random numbers, digit checks.
module binary_to_decimal_ascii_test;

  localparam int NUMBER_W = 32;
  localparam int SDATA_W  = ((NUMBER_W + 7) / 8) * 8;
  localparam int RADIX    = 10;
  localparam int SAMPLE_COUNT = 24;
  localparam int RANDOM_PER_PHASE = 159;
  // Worst number: load, one input bit per cycle, leaving the skip phase, ten digits.
  localparam int SETTLE_CYCLES = 60;

  // One expected output character and its end-of-number flag.
  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } ascii_digit_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [SDATA_W-1:0] s_tdata;                 // number
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [b2da_pkg::TDATA_OUT_W-1:0] m_tdata;   // digit_char, zero pad
  logic m_tlast;                               // last_digit

  // Percent chance per cycle that the sender or the receiver holds off.
  int send_idle_pct = 9;
  int recv_idle_pct = 74;
  int mismatch_count = 0;

  // Digits owed by the block, oldest first.
  ascii_digit_t pending_digits[$];

  // Directed numbers: decade edges, extremes and alternating bit patterns.
  // The spelled text, where given, is the expected output typed in directly;
  // an empty string leaves the row to the predictor.
  localparam logic [NUMBER_W-1:0] SAMPLE_NUMBERS [SAMPLE_COUNT] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
    32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
    32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
    32'd1000000000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };
  string sample_spelled [SAMPLE_COUNT] = '{
    "0", "1", "", "10", "", "100", "", "",
    "", "", "", "", "", "",
    "", "", "", "", "",
    "1000000000", "4294967295", "", "", ""
  };

  binary_to_decimal_ascii #(
    .INPUT_WIDTH(NUMBER_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Print one line per mismatch and count every one.
  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Split a number into decimal digits, least significant first, then queue
  // them as ASCII most significant first with the flag on the final digit.
  function automatic void predict_digits(input logic [NUMBER_W-1:0] number);
    logic [3:0] rev [20];
    logic [NUMBER_W-1:0] rest;
    ascii_digit_t d;
    int count;
    rest = number;
    count = 0;
    do begin
      rev[count] = 4'(rest % RADIX);
      count++;
      rest = rest / RADIX;
    end while (rest != 0);
    for (int k = count - 1; k >= 0; k--) begin
      d.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[k]);
      d.last = (k == 0);
      pending_digits.push_back(d);
    end
  endfunction

  // Offer one number request; idle first at the sender's rate, with noise on
  // tdata while tvalid is low. Record what it owes once it is taken.
  task automatic offer_number(input logic [NUMBER_W-1:0] number, input string spelled);
    ascii_digit_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= SDATA_W'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SDATA_W'(number);
    do @(posedge clk); while (!s_tready);
    if (spelled.len() != 0) begin
      for (int i = 0; i < spelled.len(); i++) begin
        d.ch   = b2da_pkg::CHAR_W'(spelled[i]);
        d.last = (i == spelled.len() - 1);
        pending_digits.push_back(d);
      end
    end else begin
      predict_digits(number);
    end
  endtask

  // Stall the output at the receiver's rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every accepted digit with the oldest one owed.
  always @(posedge clk) begin
    ascii_digit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digits.size() == 0) begin
        flag_mismatch($sformatf("digit 0x%02h with none owed", m_tdata));
      end else begin
        want = pending_digits.pop_front();
        if (m_tdata !== b2da_pkg::TDATA_OUT_W'(want.ch)) begin
          flag_mismatch($sformatf("digit 0x%02h, owed 0x%02h", m_tdata,
                                  b2da_pkg::TDATA_OUT_W'(want.ch)));
        end
        if (m_tlast !== want.last) begin
          flag_mismatch($sformatf("last flag %b, owed %b on digit 0x%02h",
                                  m_tlast, want.last,
                                  b2da_pkg::TDATA_OUT_W'(want.ch)));
        end
      end
    end
  end

  initial begin
    longint unsigned lo;
    longint unsigned hi;
    logic [NUMBER_W-1:0] number;
    int digits;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows run under the first idling mix.
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      offer_number(SAMPLE_NUMBERS[i], sample_spelled[i]);
    end

    // Random phases: sender light and receiver heavy, swapped, then no idling.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 9 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(4) == 0) begin
          // Full-range value so that every bit toggles.
          number = NUMBER_W'($urandom);
        end else begin
          // Pick a digit count first so short and long numbers mix evenly.
          digits = $urandom_range(10, 1);
          lo = 1;
          repeat (digits - 1) lo = lo * RADIX;
          hi = lo * RADIX - 1;
          if (digits == 1) lo = 0;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          number = NUMBER_W'($urandom_range(32'(hi), 32'(lo)));
        end
        offer_number(number, "");
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every owed digit, then give the block time to misbehave.
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
